// File: src/wlbc_pkg.sv
`timescale 1ns / 1ps
package wlbc_pkg;
  localparam int ENTRIES_DEF = 64;
  localparam logic [39:0] CAP_RESET = 40'd8388608;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] file_id;
    logic [63:0] block_offset;
    logic [31:0] block_handle;
    logic [23:0] charge;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic [40:0] total_charge;
    logic [6:0]  evicted_count;
  } out_word_t;
endpackage

// File: src/weighted_lru_block_cache.sv
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    wlbc_pkg::in_word_t
// out      out  out_valid/out_ready  wlbc_pkg::out_word_t
// cfg      in   cfg_we               capacity register (40 bits)
// One shared unit walks the slots through registered memory reads; each pass
// visits all E slots (E = ENTRIES). Lookup and erase take a search pass, plus a fix
// pass on a hit; insert adds a victim and fix pass per eviction, then an aging pass;
// clear takes no pass. Reset (rst, synchronous) clears valid bits and the sum, and loads capacity with CAP_RESET.
// in_ready is high only while idle; a finished word waits in the output
// register, and a new result is held back only while the old one waits.
module weighted_lru_block_cache #(
  parameter int ENTRIES = wlbc_pkg::ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wlbc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wlbc_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [39:0]          cfg_data
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FIND   = 9'b000000010,
    S_HIT    = 9'b000000100,
    S_FIX    = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_VICT   = 9'b000100000,
    S_AGE    = 9'b001000000,
    S_WRITE  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  // fix pass modes
  typedef enum logic [1:0] {
    M_PROMOTE = 2'd0,
    M_REMOVE  = 2'd1
  } mode_t;

  state_t state;
  mode_t mode;
  logic [39:0] capacity;
  logic [ENTRIES-1:0] valid;
  logic [63:0] mem_file [ENTRIES];
  logic [63:0] mem_off [ENTRIES];
  logic [31:0] mem_handle [ENTRIES];
  logic [23:0] mem_charge [ENTRIES];
  logic [IW-1:0] mem_rec [ENTRIES];
  logic [63:0] rd_file;
  logic [63:0] rd_off;
  logic [31:0] rd_handle;
  logic [23:0] rd_charge;
  logic [IW-1:0] rd_rec;
  logic [IW-1:0] pidx;
  logic pv;
  logic [40:0] charge_sum;
  logic [CW-1:0] count;
  wlbc_pkg::in_word_t req;
  logic [IW-1:0] idx;
  logic [IW-1:0] sel;
  logic sel_found;
  logic [IW-1:0] sel_rec;
  logic [31:0] sel_handle;
  logic [23:0] sel_charge;
  logic [IW-1:0] free_slot;
  logic free_found;
  logic [6:0] evicted;
  logic hit;
  logic [31:0] found;
  logic last;
  logic plast;

  assign last = (idx == IW'(ENTRIES - 1));
  assign plast = (pidx == IW'(ENTRIES - 1));
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    pidx <= idx;
    rd_file <= mem_file[idx];
    rd_off <= mem_off[idx];
    rd_handle <= mem_handle[idx];
    rd_charge <= mem_charge[idx];
    rd_rec <= mem_rec[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      charge_sum <= '0;
      count <= '0;
      capacity <= wlbc_pkg::CAP_RESET;
      out_valid <= 1'b0;
      mode <= M_PROMOTE;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            idx <= '0;
            pv <= 1'b0;
            sel_found <= 1'b0;
            hit <= 1'b0;
            found <= '0;
            evicted <= '0;
            free_found <= 1'b0;
            if (in_data.operation == wlbc_pkg::OP_CLEAR) begin
              valid <= '0;
              charge_sum <= '0;
              count <= '0;
              state <= S_DONE;
            end else begin
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (pv && valid[pidx] && rd_file == req.file_id &&
              rd_off == req.block_offset) begin
            sel <= pidx;
            sel_rec <= rd_rec;
            sel_handle <= rd_handle;
            sel_charge <= rd_charge;
            sel_found <= 1'b1;
          end
          pv <= 1'b1;
          idx <= last ? '0 : idx + 1'b1;
          if (pv && plast) state <= S_HIT;
        end
        S_HIT: begin
          idx <= '0;
          pv <= 1'b0;
          if (sel_found) begin
            if (evicted == '0) hit <= 1'b1;
            if (req.operation == wlbc_pkg::OP_LOOKUP) begin
              found <= sel_handle;
              mode <= M_PROMOTE;
            end else begin
              mode <= M_REMOVE;
              valid[sel] <= 1'b0;
              charge_sum <= charge_sum - 41'(sel_charge);
              count <= count - 1'b1;
            end
            state <= S_FIX;
          end else begin
            state <= (req.operation == wlbc_pkg::OP_INSERT) ? S_CHECK : S_DONE;
          end
        end
        S_FIX: begin
          if (pv) begin
            if (mode == M_PROMOTE) begin
              if (pidx == sel) mem_rec[pidx] <= '0;
              else if (valid[pidx] && rd_rec < sel_rec)
                mem_rec[pidx] <= rd_rec + 1'b1;
            end else if (valid[pidx] && rd_rec > sel_rec) begin
              mem_rec[pidx] <= rd_rec - 1'b1;
            end
          end
          pv <= 1'b1;
          idx <= last ? '0 : idx + 1'b1;
          if (pv && plast)
            state <= (req.operation == wlbc_pkg::OP_INSERT) ? S_CHECK : S_DONE;
        end
        S_CHECK: begin
          idx <= '0;
          pv <= 1'b0;
          sel_found <= 1'b0;
          if (count != '0 && ((charge_sum + 41'(req.charge)) > 41'(capacity) ||
                              count == CW'(ENTRIES)))
            state <= S_VICT;
          else
            state <= S_AGE;
        end
        S_VICT: begin
          if (pv && valid[pidx] && (!sel_found || rd_rec > sel_rec)) begin
            sel <= pidx;
            sel_rec <= rd_rec;
            sel_charge <= rd_charge;
            sel_found <= 1'b1;
          end
          pv <= 1'b1;
          idx <= last ? '0 : idx + 1'b1;
          if (pv && plast) begin
            state <= S_HIT;
            evicted <= evicted + 1'b1;
          end
        end
        S_AGE: begin
          if (pv) begin
            if (valid[pidx]) mem_rec[pidx] <= rd_rec + 1'b1;
            else if (!free_found) begin
              free_slot <= pidx;
              free_found <= 1'b1;
            end
          end
          pv <= 1'b1;
          idx <= last ? '0 : idx + 1'b1;
          if (pv && plast) state <= S_WRITE;
        end
        S_WRITE: begin
          valid[free_slot] <= 1'b1;
          mem_file[free_slot] <= req.file_id;
          mem_off[free_slot] <= req.block_offset;
          mem_handle[free_slot] <= req.block_handle;
          mem_charge[free_slot] <= req.charge;
          mem_rec[free_slot] <= '0;
          charge_sum <= charge_sum + 41'(req.charge);
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.hit <= hit;
            out_data.found_handle <= found;
            out_data.total_charge <= charge_sum;
            out_data.evicted_count <= evicted;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/sv/tb_weighted_lru_block_cache.sv
`timescale 1ns / 1ps
module tb_weighted_lru_block_cache;

  localparam int SLOTS = wlbc_pkg::ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  wlbc_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wlbc_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [39:0] cfg_data = '0;

  weighted_lru_block_cache u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cache shadow
  logic        sh_valid [SLOTS];
  logic [63:0] sh_file [SLOTS];
  logic [63:0] sh_offset [SLOTS];
  logic [31:0] sh_handle [SLOTS];
  logic [23:0] sh_charge [SLOTS];
  int          sh_rank [SLOTS];
  logic [40:0] sh_sum;
  logic [39:0] sh_capacity;

  wlbc_pkg::out_word_t expected_words[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  logic [63:0] key_file [48];
  logic [63:0] key_offset [48];

  function automatic int find_slot(logic [63:0] f, logic [63:0] o);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_file[i] == f && sh_offset[i] == o) return i;
    return -1;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && i != s && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
    sh_valid[s] = 1'b0;
    sh_sum = sh_sum - sh_charge[s];
  endfunction

  function automatic int oldest_slot();
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && (b < 0 || sh_rank[i] > sh_rank[b])) b = i;
    return b;
  endfunction

  function automatic wlbc_pkg::out_word_t cache_access(wlbc_pkg::in_word_t w);
    wlbc_pkg::out_word_t r;
    int s;
    int ev;
    r = '0;
    ev = 0;
    s = find_slot(w.file_id, w.block_offset);
    case (wlbc_pkg::op_t'(w.operation))
      wlbc_pkg::OP_LOOKUP: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          r.found_handle = sh_handle[s];
          for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && i != s && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
          sh_rank[s] = 0;
        end
      end
      wlbc_pkg::OP_INSERT: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          drop_slot(s);
        end
        while ({1'b0, sh_sum} + w.charge > {2'b0, sh_capacity} && live_count() > 0) begin
          drop_slot(oldest_slot());
          ev++;
        end
        if (live_count() >= SLOTS) begin
          drop_slot(oldest_slot());
          ev++;
        end
        s = 0;
        for (int i = SLOTS - 1; i >= 0; i--) if (!sh_valid[i]) s = i;
        for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) sh_rank[i]++;
        sh_valid[s] = 1'b1;
        sh_file[s] = w.file_id;
        sh_offset[s] = w.block_offset;
        sh_handle[s] = w.block_handle;
        sh_charge[s] = w.charge;
        sh_rank[s] = 0;
        sh_sum = sh_sum + w.charge;
      end
      wlbc_pkg::OP_ERASE: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          drop_slot(s);
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;
        sh_sum = '0;
      end
    endcase
    r.total_charge = sh_sum;
    r.evicted_count = ev[6:0];
    return r;
  endfunction

  task automatic send_word(wlbc_pkg::op_t op, logic [63:0] f, logic [63:0] o,
                           logic [31:0] h, logic [23:0] c);
    wlbc_pkg::in_word_t w;
    w.operation = op;
    w.file_id = f;
    w.block_offset = o;
    w.block_handle = h;
    w.charge = c;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(cache_access(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [39:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_capacity = v;
  endtask

  task automatic test_basic_ops();
    send_word(wlbc_pkg::OP_LOOKUP, 64'd1, 64'd2, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_word(wlbc_pkg::OP_INSERT, 64'd1, 64'd2, 32'hDEAD_BEEF, 24'd100);
    send_word(wlbc_pkg::OP_LOOKUP, 64'd1, 64'd2, 32'd0, 24'd0);
    send_word(wlbc_pkg::OP_INSERT, '1, '1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_word(wlbc_pkg::OP_INSERT, '0, '0, 32'h0, 24'h0);
    send_word(wlbc_pkg::OP_INSERT, 64'd1, 64'd2, 32'h1234_5678, 24'd7);
    send_word(wlbc_pkg::OP_LOOKUP, '1, '1, 32'd0, 24'd0);
    send_word(wlbc_pkg::OP_ERASE, 64'd1, 64'd2, 32'd0, 24'd0);
    send_word(wlbc_pkg::OP_ERASE, 64'd1, 64'd2, 32'd0, 24'd0);
    send_word(wlbc_pkg::OP_LOOKUP, '0, '0, 32'd0, 24'd0);
    send_word(wlbc_pkg::OP_CLEAR, 64'd5, 64'd5, 32'd5, 24'd5);
    send_word(wlbc_pkg::OP_LOOKUP, '1, '1, 32'd0, 24'd0);
  endtask

  task automatic test_over_capacity();
    set_capacity(40'd1000);
    send_word(wlbc_pkg::OP_INSERT, 64'd10, 64'd0, 32'd1, 24'd400);
    send_word(wlbc_pkg::OP_INSERT, 64'd11, 64'd0, 32'd2, 24'd400);
    send_word(wlbc_pkg::OP_INSERT, 64'd12, 64'd0, 32'd3, 24'd400);
    send_word(wlbc_pkg::OP_INSERT, 64'd13, 64'd0, 32'd4, 24'd5000);
    send_word(wlbc_pkg::OP_LOOKUP, 64'd13, 64'd0, 32'd0, 24'd0);
    set_capacity(40'd0);
    send_word(wlbc_pkg::OP_INSERT, 64'd14, 64'd0, 32'd5, 24'd0);
    send_word(wlbc_pkg::OP_INSERT, 64'd15, 64'd0, 32'd6, 24'd1);
    send_word(wlbc_pkg::OP_CLEAR, 64'd0, 64'd0, 32'd0, 24'd0);
  endtask

  task automatic test_full_table();
    set_capacity('1);
    for (int i = 0; i < SLOTS + 6; i++)
      send_word(wlbc_pkg::OP_INSERT, 64'(i), 64'(i * 3), $urandom, 24'hFF_FFFF);
    send_word(wlbc_pkg::OP_LOOKUP, 64'd0, 64'd0, 32'd0, 24'd0);
    send_word(wlbc_pkg::OP_LOOKUP, 64'd20, 64'd60, 32'd0, 24'd0);
    set_capacity(40'd1);
    send_word(wlbc_pkg::OP_INSERT, 64'd99, 64'd99, 32'd9, 24'd1);
    send_word(wlbc_pkg::OP_CLEAR, 64'd0, 64'd0, 32'd0, 24'd0);
  endtask

  task automatic random_phase(int count, logic [39:0] cap, int max_charge);
    int k;
    int pick;
    logic [63:0] f;
    logic [63:0] o;
    logic [23:0] c;
    set_capacity(cap);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 47);
      f = key_file[k];
      o = key_offset[k];
      if ($urandom_range(0, 9) == 0) begin
        f = {$urandom, $urandom};
        o = {$urandom, $urandom};
      end
      c = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, max_charge));
      pick = $urandom_range(0, 99);
      if (pick < 42) send_word(wlbc_pkg::OP_INSERT, f, o, $urandom, c);
      else if (pick < 80) send_word(wlbc_pkg::OP_LOOKUP, f, o, $urandom, 24'($urandom));
      else if (pick < 98) send_word(wlbc_pkg::OP_ERASE, f, o, $urandom, 24'($urandom));
      else send_word(wlbc_pkg::OP_CLEAR, f, o, $urandom, 24'($urandom));
    end
  endtask

  task automatic test_random();
    random_phase(400, wlbc_pkg::CAP_RESET, 300000);
    random_phase(300, 40'd2000000, 200000);
    random_phase(300, 40'({$urandom, $urandom}), 24'hFF_FFFF);
    random_phase(300, '1, 100000);
    random_phase(200, 40'd50, 40);
    idle_on = 1'b0;
    random_phase(250, wlbc_pkg::CAP_RESET, 400000);
  endtask

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_data);
        end else begin
          wlbc_pkg::out_word_t e;
          e = expected_words.pop_front();
          if (e.hit !== out_data.hit || e.found_handle !== out_data.found_handle ||
              e.total_charge !== out_data.total_charge ||
              e.evicted_count !== out_data.evicted_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0d h=%h sum=%0d ev=%0d got hit=%0d h=%h sum=%0d ev=%0d",
                       e.hit, e.found_handle, e.total_charge, e.evicted_count,
                       out_data.hit, out_data.found_handle, out_data.total_charge,
                       out_data.evicted_count);
          end
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0;
      sh_rank[i] = 0;
    end
    sh_sum = '0;
    sh_capacity = wlbc_pkg::CAP_RESET;
    key_file[0] = '0;
    key_offset[0] = '0;
    key_file[1] = '1;
    key_offset[1] = '1;
    for (int i = 2; i < 48; i++) begin
      key_file[i] = (i < 24) ? 64'(i % 5) : {$urandom, $urandom};
      key_offset[i] = (i < 24) ? 64'(i) : {$urandom, $urandom};
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_over_capacity();
    test_full_table();
    test_random();
    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
